@@ sv/card_credit_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// card_credit_table_core_defines
// Assertion macros shared by the card credit table RTL.
// ----------------------------------------------------------------------------
`ifndef CARD_CREDIT_TABLE_CORE_DEFINES_SVH
`define CARD_CREDIT_TABLE_CORE_DEFINES_SVH

// Plain property, checked outside reset.
`define CCRED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ccred assertion failed");

// Same-cycle implication, checked outside reset.
`define CCRED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccred implication failed");

// Next-cycle implication, checked outside reset.
`define CCRED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccred sequence failed");

`endif

@@ sv/ccred_pkg.sv @@
// ----------------------------------------------------------------------------
// ccred_pkg
// Types and constants shared by the card credit table modules.
// ----------------------------------------------------------------------------
package ccred_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int REQ_TYPE_W      = 3;
    localparam int KEY_W           = 32;
    localparam int AMOUNT_W        = 32;
    localparam int BAL_W           = 32;
    localparam int STATUS_W        = 3;
    localparam int SLOT_W          = 4;

    localparam logic [BAL_W-1:0] BAL_MAX = '1;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ADD_CARD    = 3'd0,
        REQ_REMOVE_CARD = 3'd1,
        REQ_QUERY       = 3'd2,
        REQ_CREDIT      = 3'd3,
        REQ_DEDUCT      = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_DUPLICATE    = 3'd2,
        ST_FULL         = 3'd3,
        ST_INSUFFICIENT = 3'd4,
        ST_ZERO         = 3'd5,
        ST_SATURATED    = 3'd6
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch request, arm scan
        logic rd;     // read one slot at scan counter
        logic exec;   // apply request, load result beat
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;      // scan counter at last slot
        logic out_free;  // result register can take a beat
    } t_dp_sts;

endpackage

@@ sv/ccred_req_if.sv @@
// ----------------------------------------------------------------------------
// ccred_req_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface ccred_req_if;
    import ccred_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [KEY_W-1:0]      card_key;
    logic [AMOUNT_W-1:0]   amount;

    modport source (output valid, output req_type, output card_key, output amount,
                    input ready);
    modport sink   (input valid, input req_type, input card_key, input amount,
                    output ready);
endinterface

@@ sv/ccred_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ccred_rsp_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface ccred_rsp_if;
    import ccred_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BAL_W-1:0]    balance;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output balance, output slot,
                    input ready);
    modport sink   (input valid, input status, input balance, input slot,
                    output ready);
endinterface

@@ sv/ccred_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccred_ctrl
// Sequencer: accept, scan all slots, drain compare stage, execute.
// ----------------------------------------------------------------------------
`include "card_credit_table_core_defines.svh"

module ccred_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  ccred_pkg::t_dp_sts  i_sts,
    output ccred_pkg::t_ctrl_cmd o_cmd
);
    import ccred_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_req_valid;
        o_cmd.rd   = (r_state == S_SCAN);
        o_cmd.exec = (r_state == S_EXEC) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.last) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CCRED_ASSERT_NXT(a_load_starts_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN)
    `CCRED_ASSERT_IMP(a_exec_needs_room, i_clk, i_rst_n, o_cmd.exec, i_sts.out_free)
    `CCRED_ASSERT_IMP(a_flush_after_scan, i_clk, i_rst_n, r_state == S_FLUSH,
                      $past(r_state == S_SCAN))

endmodule

@@ sv/ccred_dp.sv @@
// ----------------------------------------------------------------------------
// ccred_dp
// Datapath: slot key/balance memories, valid bits, scan compare, update.
// ----------------------------------------------------------------------------
`include "card_credit_table_core_defines.svh"

module ccred_dp #(
    parameter int ENTRIES = ccred_pkg::DEFAULT_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ccred_pkg::t_ctrl_cmd            i_cmd,
    output ccred_pkg::t_dp_sts              o_sts,
    input  logic [ccred_pkg::REQ_TYPE_W-1:0] i_req_type,
    input  logic [ccred_pkg::KEY_W-1:0]      i_card_key,
    input  logic [ccred_pkg::AMOUNT_W-1:0]   i_amount,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output logic [ccred_pkg::STATUS_W-1:0]   o_status,
    output logic [ccred_pkg::BAL_W-1:0]      o_balance,
    output logic [ccred_pkg::SLOT_W-1:0]     o_slot
);
    import ccred_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // slot storage; keys unwritten until a card is added
    logic [KEY_W-1:0] mem_key [ENTRIES];
    logic [BAL_W-1:0] mem_bal [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    // latched request
    logic [REQ_TYPE_W-1:0] r_req_type;
    logic [KEY_W-1:0]      r_req_key;
    logic [AMOUNT_W-1:0]   r_req_amt;

    // scan
    logic [IW-1:0]    r_cnt;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic [KEY_W-1:0] r_key_rd;
    logic [BAL_W-1:0] r_bal_rd;
    logic             hit_now;
    logic             free_now;

    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    logic [BAL_W-1:0] r_hit_bal;
    logic             r_free;
    logic [IW-1:0]    r_free_idx;

    // execute
    logic [BAL_W:0]    sum;
    logic [BAL_W:0]    diff;
    t_status           n_status;
    logic [BAL_W-1:0]  n_balance;
    logic [IW-1:0]     n_slot_idx;
    logic              we_key;
    logic              we_bal;
    logic [IW-1:0]     wr_idx;
    logic [BAL_W-1:0]  wr_bal;
    logic              set_valid;
    logic              clr_valid;

    // result register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [BAL_W-1:0]    r_balance;
    logic [SLOT_W-1:0]   r_slot;

    assign o_sts.last     = (r_cnt == IW'(ENTRIES - 1));
    assign o_sts.out_free = !r_out_vld || i_rsp_ready;

    assign hit_now  = r_cmp_vld && r_valid[r_cmp_idx] && (r_key_rd == r_req_key);
    assign free_now = r_cmp_vld && !r_valid[r_cmp_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_req_key  <= i_card_key;
            r_req_amt  <= i_amount;
        end
        if (i_cmd.rd) begin
            r_key_rd  <= mem_key[r_cnt];
            r_bal_rd  <= mem_bal[r_cnt];
            r_cmp_idx <= r_cnt;
        end
        if (hit_now && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_bal <= r_bal_rd;
        end
        if (free_now && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_cnt  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.rd) r_cnt <= r_cnt + 1'b1;
                if (hit_now)  r_hit  <= 1'b1;
                if (free_now) r_free <= 1'b1;
            end
        end
    end

    assign sum  = {1'b0, r_hit_bal} + {1'b0, r_req_amt};
    assign diff = {1'b0, r_hit_bal} - {1'b0, r_req_amt};

    always_comb begin
        n_status   = ST_NOT_FOUND;
        n_balance  = '0;
        n_slot_idx = '0;
        we_key     = 1'b0;
        we_bal     = 1'b0;
        wr_idx     = r_hit_idx;
        wr_bal     = '0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        unique case (t_req_type'(r_req_type))
            REQ_ADD_CARD: begin
                if (r_hit) begin
                    n_status = ST_DUPLICATE;
                end else if (!r_free) begin
                    n_status = ST_FULL;
                end else begin
                    n_status   = ST_OK;
                    n_slot_idx = r_free_idx;
                    wr_idx     = r_free_idx;
                    we_key     = 1'b1;
                    we_bal     = 1'b1;
                    set_valid  = 1'b1;
                end
            end
            REQ_REMOVE_CARD: begin
                if (r_hit) begin
                    n_status   = ST_OK;
                    n_slot_idx = r_hit_idx;
                    clr_valid  = 1'b1;
                end
            end
            REQ_QUERY: begin
                if (r_hit) begin
                    n_slot_idx = r_hit_idx;
                    if (r_hit_bal == '0) begin
                        n_status = ST_ZERO;
                    end else begin
                        n_status  = ST_OK;
                        n_balance = r_hit_bal;
                    end
                end
            end
            REQ_CREDIT: begin
                if (r_hit) begin
                    n_slot_idx = r_hit_idx;
                    we_bal     = 1'b1;
                    if (sum[BAL_W]) begin
                        n_status  = ST_SATURATED;
                        n_balance = BAL_MAX;
                        wr_bal    = BAL_MAX;
                    end else begin
                        n_status  = ST_OK;
                        n_balance = sum[BAL_W-1:0];
                        wr_bal    = sum[BAL_W-1:0];
                    end
                end
            end
            REQ_DEDUCT: begin
                if (r_hit) begin
                    n_slot_idx = r_hit_idx;
                    if (diff[BAL_W]) begin
                        n_status  = ST_INSUFFICIENT;
                        n_balance = r_hit_bal;
                    end else begin
                        n_status  = ST_OK;
                        n_balance = diff[BAL_W-1:0];
                        we_bal    = 1'b1;
                        wr_bal    = diff[BAL_W-1:0];
                    end
                end
            end
            default: n_status = ST_NOT_FOUND;  // unused request codes
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we_key) mem_key[wr_idx] <= r_req_key;
        if (i_cmd.exec && we_bal) mem_bal[wr_idx] <= wr_bal;
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_balance <= n_balance;
            r_slot    <= SLOT_W'(n_slot_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.exec && set_valid) r_valid[wr_idx] <= 1'b1;
            if (i_cmd.exec && clr_valid) r_valid[wr_idx] <= 1'b0;
            if (i_cmd.exec) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_balance   = r_balance;
    assign o_slot      = r_slot;

    `CCRED_ASSERT_IMP(a_hit_is_valid, i_clk, i_rst_n, i_cmd.exec && r_hit,
                      r_valid[r_hit_idx])
    `CCRED_ASSERT_IMP(a_free_is_empty, i_clk, i_rst_n, i_cmd.exec && r_free,
                      !r_valid[r_free_idx])
    `CCRED_ASSERT_NXT(a_exec_gives_beat, i_clk, i_rst_n, i_cmd.exec, r_out_vld)

endmodule

@@ sv/card_credit_table_core.sv @@
// A request is handled by a scan of all slots, a compare drain and an
// execute step; a new request is accepted only after the previous one has
// executed. The slot scan reads one key/balance pair per cycle from the
// slot memories. A waiting result beat does not block intake.
// Reset (synchronous, active low) clears all valid marks and the handshake
// state; no clearing pass, the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
// card_credit_table_core
// Card key table with per-card credit balance: add, remove, query, credit
// and deduct requests, each answered by one result beat.
// ----------------------------------------------------------------------------
module card_credit_table_core #(
    parameter int ENTRIES = ccred_pkg::DEFAULT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccred_req_if.sink   i_req,
    ccred_rsp_if.source o_rsp
);
    import ccred_pkg::*;

    // Split: ccred_ctrl sequences a request (idle -> scan -> drain -> execute),
    // ccred_dp holds the slot memories, valid marks, compare stage and the
    // result register. They talk only through the command/status structs.
    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    ccred_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Lookup rule: the lowest valid slot with a matching key wins; a new card
    // takes the lowest slot without a valid mark. Both are found in one scan.
    // A slot's balance is written to zero whenever its card is added, so the
    // balance memory itself needs no reset.
    ccred_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req.req_type),
        .i_card_key  (i_req.card_key),
        .i_amount    (i_req.amount),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_status    (o_rsp.status),
        .o_balance   (o_rsp.balance),
        .o_slot      (o_rsp.slot)
    );

endmodule
